FILE: rtl/jpa_pkg.sv
`default_nettype none

package jpa_pkg;

   localparam int ReqTypeWidth  = 4;
   localparam int FrameWidth    = 32;
   localparam int PortWidth     = 8;
   localparam int CountWidth    = 8;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 8;

   // request codes
   localparam logic [ReqTypeWidth-1:0] REQ_UP           = 4'd0;
   localparam logic [ReqTypeWidth-1:0] REQ_DOWN         = 4'd1;
   localparam logic [ReqTypeWidth-1:0] REQ_LEFT         = 4'd2;
   localparam logic [ReqTypeWidth-1:0] REQ_RIGHT        = 4'd3;
   localparam logic [ReqTypeWidth-1:0] REQ_RELEASE_X    = 4'd4;
   localparam logic [ReqTypeWidth-1:0] REQ_RELEASE_Y    = 4'd5;
   localparam logic [ReqTypeWidth-1:0] REQ_RELEASE_XY   = 4'd6;
   localparam logic [ReqTypeWidth-1:0] REQ_PRESS_FIRE   = 4'd7;
   localparam logic [ReqTypeWidth-1:0] REQ_RELEASE_FIRE = 4'd8;
   localparam logic [ReqTypeWidth-1:0] REQ_FRAME_TICK   = 4'd9;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_AUTOFIRE_ENABLE = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_BURST_MODE      = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_BURST_BULLETS   = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_AUTOFIRE_DELAY  = 2'd3;

   localparam logic [CountWidth-1:0] BURST_BULLETS_RESET  = 8'd3;
   localparam logic [CountWidth-1:0] AUTOFIRE_DELAY_RESET = 8'd5;

   // axis positions, two's complement
   localparam logic [1:0] AXIS_MID = 2'd0;
   localparam logic [1:0] AXIS_POS = 2'd1;
   localparam logic [1:0] AXIS_NEG = 2'd3;

   localparam logic [PortWidth-1:0] PORT_IDLE = 8'hFF;

   typedef struct packed {
      logic                  autofire_enable;
      logic                  burst_mode;
      logic [CountWidth-1:0] burst_bullets;
      logic [CountWidth-1:0] autofire_delay;
   } csr_type;

   typedef struct packed {
      logic [1:0]            axis_x;
      logic [1:0]            axis_y;
      logic                  fire_button;
      logic [CountWidth-1:0] bullets_left;
      logic                  unlimited_run;
      logic [FrameWidth-1:0] next_press_frame;
      logic [FrameWidth-1:0] next_release_frame;
   } state_type;

   typedef struct packed {
      logic [PortWidth-1:0] port_value;
      logic                 autofiring;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/jpa_channels.sv
`default_nettype none

interface jpa_req_if;
   logic                                valid;
   logic                                ready;
   logic [jpa_pkg::ReqTypeWidth-1:0]    req_type;
   logic [jpa_pkg::FrameWidth-1:0]      frame_number;

   modport source (output valid, output req_type, output frame_number, input ready);
   modport sink (input valid, input req_type, input frame_number, output ready);
   modport monitor (input valid, input ready, input req_type, input frame_number);
endinterface

interface jpa_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [jpa_pkg::PortWidth-1:0]    port_value;
   logic                             autofiring;

   modport source (output valid, output port_value, output autofiring, input ready);
   modport sink (input valid, input port_value, input autofiring, output ready);
   modport monitor (input valid, input ready, input port_value, input autofiring);
endinterface

`default_nettype wire

FILE: rtl/jpa_csr.sv
`default_nettype none

module jpa_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_enable,
   input  wire logic [jpa_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [jpa_pkg::CsrDataWidth-1:0]   csr_write_data,
   output jpa_pkg::csr_type                        cfg
);

   jpa_pkg::csr_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            jpa_pkg::CSR_AUTOFIRE_ENABLE: cfg_in.autofire_enable = csr_write_data[0];
            jpa_pkg::CSR_BURST_MODE:      cfg_in.burst_mode      = csr_write_data[0];
            jpa_pkg::CSR_BURST_BULLETS:   cfg_in.burst_bullets   = csr_write_data;
            jpa_pkg::CSR_AUTOFIRE_DELAY:  cfg_in.autofire_delay  = csr_write_data;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.autofire_enable <= 1'b0;
         cfg_ff.burst_mode      <= 1'b0;
         cfg_ff.burst_bullets   <= jpa_pkg::BURST_BULLETS_RESET;
         cfg_ff.autofire_delay  <= jpa_pkg::AUTOFIRE_DELAY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/jpa_engine.sv
`default_nettype none

module jpa_engine (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               process,
   input  wire logic [jpa_pkg::ReqTypeWidth-1:0]   req_type,
   input  wire logic [jpa_pkg::FrameWidth-1:0]     frame_number,
   input  wire jpa_pkg::csr_type                   cfg,
   output jpa_pkg::result_type                     result
);

   jpa_pkg::state_type state_ff, state_in;

   logic [jpa_pkg::FrameWidth-1:0]  delay_ext;
   logic [jpa_pkg::FrameWidth-1:0]  frame_plus_delay;
   logic [jpa_pkg::FrameWidth-1:0]  frame_plus_2delay;
   logic [jpa_pkg::FrameWidth-1:0]  release_plus_delay;
   logic                            run_active;
   logic                            press_hit;
   logic                            release_hit;
   logic [jpa_pkg::CountWidth-1:0]  bullets_dec;
   logic                            more;
   logic [jpa_pkg::PortWidth-1:0]   port;

   assign delay_ext          = {{(jpa_pkg::FrameWidth-jpa_pkg::CountWidth){1'b0}},
                                cfg.autofire_delay};
   assign frame_plus_delay   = frame_number + delay_ext;
   assign frame_plus_2delay  = frame_number + {delay_ext[jpa_pkg::FrameWidth-2:0], 1'b0};
   assign release_plus_delay = state_ff.next_release_frame + delay_ext;
   assign run_active         = state_ff.unlimited_run || (state_ff.bullets_left != '0);
   assign press_hit          = (frame_number == state_ff.next_press_frame);
   // after a press on this tick the release frame is frame + delay,
   // so it matches the same tick only for a zero delay
   assign release_hit        = press_hit ? (cfg.autofire_delay == '0)
                                         : (frame_number == state_ff.next_release_frame);
   assign bullets_dec        = state_ff.bullets_left - 1'b1;
   assign more               = state_ff.unlimited_run || (bullets_dec != '0);

   always_comb begin
      state_in = state_ff;
      case (req_type)
         jpa_pkg::REQ_UP:         state_in.axis_y = jpa_pkg::AXIS_NEG;
         jpa_pkg::REQ_DOWN:       state_in.axis_y = jpa_pkg::AXIS_POS;
         jpa_pkg::REQ_LEFT:       state_in.axis_x = jpa_pkg::AXIS_NEG;
         jpa_pkg::REQ_RIGHT:      state_in.axis_x = jpa_pkg::AXIS_POS;
         jpa_pkg::REQ_RELEASE_X:  state_in.axis_x = jpa_pkg::AXIS_MID;
         jpa_pkg::REQ_RELEASE_Y:  state_in.axis_y = jpa_pkg::AXIS_MID;
         jpa_pkg::REQ_RELEASE_XY: begin
            state_in.axis_x = jpa_pkg::AXIS_MID;
            state_in.axis_y = jpa_pkg::AXIS_MID;
         end
         jpa_pkg::REQ_PRESS_FIRE: begin
            if (!cfg.autofire_enable) begin
               state_in.fire_button = 1'b1;
            end else if (run_active && !cfg.burst_mode) begin
               state_in.fire_button        = 1'b0;
               state_in.bullets_left       = '0;
               state_in.unlimited_run      = 1'b0;
               state_in.next_press_frame   = '0;
               state_in.next_release_frame = '0;
            end else begin
               // reload the magazine; a fresh run also presses the button
               if (cfg.burst_mode) begin
                  state_in.bullets_left  = cfg.burst_bullets;
                  state_in.unlimited_run = 1'b0;
               end else begin
                  state_in.bullets_left  = '0;
                  state_in.unlimited_run = 1'b1;
               end
               if (!run_active) begin
                  state_in.fire_button        = 1'b1;
                  state_in.next_release_frame = frame_plus_delay;
               end
            end
         end
         jpa_pkg::REQ_RELEASE_FIRE: begin
            if (!cfg.autofire_enable) begin
               state_in.fire_button = 1'b0;
            end
         end
         jpa_pkg::REQ_FRAME_TICK: begin
            if (run_active) begin
               if (press_hit) begin
                  state_in.fire_button        = 1'b1;
                  state_in.next_release_frame = frame_plus_delay;
               end
               if (release_hit) begin
                  state_in.fire_button = 1'b0;
                  if (!state_ff.unlimited_run) begin
                     state_in.bullets_left = bullets_dec;
                  end
                  if (more) begin
                     state_in.next_press_frame = press_hit ? frame_plus_2delay
                                                           : release_plus_delay;
                  end else begin
                     state_in.bullets_left       = '0;
                     state_in.unlimited_run      = 1'b0;
                     state_in.next_press_frame   = '0;
                     state_in.next_release_frame = '0;
                  end
               end
            end
         end
         default: state_in = state_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.axis_x             <= jpa_pkg::AXIS_MID;
         state_ff.axis_y             <= jpa_pkg::AXIS_MID;
         state_ff.fire_button        <= 1'b0;
         state_ff.bullets_left       <= '0;
         state_ff.unlimited_run      <= 1'b0;
         state_ff.next_press_frame   <= '0;
         state_ff.next_release_frame <= '0;
      end else if (process) begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      port = jpa_pkg::PORT_IDLE;
      if (state_in.axis_y == jpa_pkg::AXIS_NEG) port[0] = 1'b0;
      if (state_in.axis_y == jpa_pkg::AXIS_POS) port[1] = 1'b0;
      if (state_in.axis_x == jpa_pkg::AXIS_NEG) port[2] = 1'b0;
      if (state_in.axis_x == jpa_pkg::AXIS_POS) port[3] = 1'b0;
      if (state_in.fire_button)                 port[4] = 1'b0;
   end

   assign result.port_value = port;
   assign result.autofiring = state_in.unlimited_run || (state_in.bullets_left != '0);

endmodule

`default_nettype wire

FILE: rtl/joystick_port_with_autofire_core.sv
// Digital joystick port with autofire. Each request transaction (a direction
// or fire event, or an end-of-frame tick with the frame number) yields exactly
// one response: the active-low port byte and the autofiring flag. Throughput
// is one transaction per cycle while the response side is not stalled. An
// accepted request is held in the request register; the engine state update
// and the response register are loaded from it together. Configuration
// writes take effect on the next cycle and should be made while no transaction
// is in flight.
`default_nettype none

module joystick_port_with_autofire_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   jpa_req_if.sink                                 req_chan,
   jpa_rsp_if.source                               rsp_chan,
   input  wire logic                               csr_write_enable,
   input  wire logic [jpa_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [jpa_pkg::CsrDataWidth-1:0]   csr_write_data
);

   logic                              in_valid_ff, in_valid_in;
   logic [jpa_pkg::ReqTypeWidth-1:0]  req_type_ff;
   logic [jpa_pkg::FrameWidth-1:0]    frame_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   jpa_pkg::result_type               rsp_data_ff;
   jpa_pkg::result_type               result;
   jpa_pkg::csr_type                  cfg;
   logic                              advance;
   logic                              process;
   logic                              req_accept;

   assign advance    = !rsp_valid_ff || rsp_chan.ready;
   assign process    = in_valid_ff && advance;
   assign req_accept = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (process) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_type_ff <= req_chan.req_type;
         frame_ff    <= req_chan.frame_number;
      end
      if (process) begin
         rsp_data_ff <= result;
      end
   end

   jpa_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   jpa_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .process      (process),
      .req_type     (req_type_ff),
      .frame_number (frame_ff),
      .cfg          (cfg),
      .result       (result)
   );

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.port_value = rsp_data_ff.port_value;
   assign rsp_chan.autofiring = rsp_data_ff.autofiring;

endmodule

`default_nettype wire

FILE: rtl/jpa_checker.sv
`default_nettype none

module jpa_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   input  wire logic [jpa_pkg::PortWidth-1:0]   rsp_port_value,
   input  wire logic                            rsp_autofiring
);

   // a stalled response transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_port_value) && $stable(rsp_autofiring))
      else $error("stalled response changed");

   // unused port bits are always high
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_port_value[7:5] == 3'b111))
      else $error("unused port bits low");

   // an axis cannot point both ways
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_port_value[0] || rsp_port_value[1]))
      else $error("up and down both active");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_port_value[2] || rsp_port_value[3]))
      else $error("left and right both active");

   // no response right out of reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind joystick_port_with_autofire_core jpa_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_port_value (rsp_chan.port_value),
   .rsp_autofiring (rsp_chan.autofiring)
);

`default_nettype wire

FILE: tb/sv/testbench.sv
`default_nettype none

module testbench;
   import jpa_pkg::*;

   localparam int IdleLimit     = 3000;
   localparam int DrainCycles   = 8;
   localparam int HoldOffCycles = 300;
   localparam int RandomPhases  = 12;
   localparam int PhaseItems    = 150;

   localparam logic [ReqTypeWidth-1:0] REQ_UNUSED_LOW  = REQ_FRAME_TICK + 1'b1;
   localparam logic [ReqTypeWidth-1:0] REQ_UNUSED_HIGH = '1;

   typedef struct packed {
      logic [ReqTypeWidth-1:0] kind;
      logic [FrameWidth-1:0]   frame;
   } stick_action_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_write_enable;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_write_data;

   jpa_req_if req_bus ();
   jpa_rsp_if rsp_bus ();

   joystick_port_with_autofire_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   stick_action_type action_backlog[$];
   result_type       port_forecast[$];

   csr_type   cfg;
   state_type joy = '0;   // centered, released, no run

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   logic        hold_off_request = 1'b0;
   logic        hold_off_served = 1'b0;
   int          hold_off_left = 0;
   logic        req_taken = 1'b0;
   logic        rsp_taken = 1'b0;
   int          idle_cycles = 0;
   int          error_count = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic run_in_progress();
      return joy.unlimited_run || joy.bullets_left != '0;
   endfunction

   task automatic reload_magazine();
      if (cfg.burst_mode) begin
         joy.bullets_left  = cfg.burst_bullets;
         joy.unlimited_run = 1'b0;
      end else begin
         joy.bullets_left  = '0;
         joy.unlimited_run = 1'b1;
      end
   endtask

   task automatic stop_run();
      joy.fire_button        = 1'b0;
      joy.bullets_left       = '0;
      joy.unlimited_run      = 1'b0;
      joy.next_press_frame   = '0;
      joy.next_release_frame = '0;
   endtask

   task automatic update_stick(input logic [ReqTypeWidth-1:0] kind,
                               input logic [FrameWidth-1:0] frame);
      logic         more;
      logic [FrameWidth-1:0] gap;
      result_type   outcome;
      gap = FrameWidth'(cfg.autofire_delay);
      case (kind)
         REQ_UP:         joy.axis_y = AXIS_NEG;
         REQ_DOWN:       joy.axis_y = AXIS_POS;
         REQ_LEFT:       joy.axis_x = AXIS_NEG;
         REQ_RIGHT:      joy.axis_x = AXIS_POS;
         REQ_RELEASE_X:  joy.axis_x = AXIS_MID;
         REQ_RELEASE_Y:  joy.axis_y = AXIS_MID;
         REQ_RELEASE_XY: begin
            joy.axis_x = AXIS_MID;
            joy.axis_y = AXIS_MID;
         end
         REQ_PRESS_FIRE: begin
            if (!cfg.autofire_enable) begin
               joy.fire_button = 1'b1;
            end else if (run_in_progress()) begin
               if (cfg.burst_mode) reload_magazine();
               else stop_run();
            end else begin
               reload_magazine();
               joy.fire_button        = 1'b1;
               joy.next_release_frame = frame + gap;
            end
         end
         REQ_RELEASE_FIRE: begin
            if (!cfg.autofire_enable) joy.fire_button = 1'b0;
         end
         REQ_FRAME_TICK: begin
            if (run_in_progress()) begin
               if (frame == joy.next_press_frame) begin
                  joy.fire_button        = 1'b1;
                  joy.next_release_frame = joy.next_press_frame + gap;
               end
               if (frame == joy.next_release_frame) begin
                  joy.fire_button = 1'b0;
                  if (joy.unlimited_run) begin
                     more = 1'b1;
                  end else begin
                     joy.bullets_left = joy.bullets_left - 1'b1;
                     more = joy.bullets_left != '0;
                  end
                  if (more) joy.next_press_frame = joy.next_release_frame + gap;
                  else stop_run();
               end
            end
         end
         default: ;
      endcase
      outcome.port_value = PORT_IDLE;
      if (joy.axis_y == AXIS_NEG) outcome.port_value[0] = 1'b0;
      if (joy.axis_y == AXIS_POS) outcome.port_value[1] = 1'b0;
      if (joy.axis_x == AXIS_NEG) outcome.port_value[2] = 1'b0;
      if (joy.axis_x == AXIS_POS) outcome.port_value[3] = 1'b0;
      if (joy.fire_button) outcome.port_value[4] = 1'b0;
      outcome.autofiring = run_in_progress();
      port_forecast.push_back(outcome);
   endtask

   // ---------------------------------------------------------------- driver

   always @(negedge clock) begin : drive_req
      stick_action_type next_action;
      if (reset) begin
         req_bus.valid        <= 1'b0;
         req_bus.req_type     <= REQ_UP;
         req_bus.frame_number <= '0;
      end else if (!req_bus.valid || req_taken) begin
         if (action_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_action = action_backlog.pop_front();
            req_bus.valid        <= 1'b1;
            req_bus.req_type     <= next_action.kind;
            req_bus.frame_number <= next_action.frame;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : drive_rsp_ready
      if (hold_off_request && !hold_off_served) begin
         hold_off_served <= 1'b1;
         hold_off_left   <= HoldOffCycles;
         rsp_bus.ready   <= 1'b0;
      end else if (hold_off_left != 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin : observe
      result_type seen;
      result_type want;
      req_taken = !reset && req_bus.valid && req_bus.ready;
      rsp_taken = !reset && rsp_bus.valid && rsp_bus.ready;
      idle_cycles = (req_taken || rsp_taken) ? 0 : idle_cycles + 1;
      // predict first: a response never overtakes its own request
      if (req_taken) update_stick(req_bus.req_type, req_bus.frame_number);
      if (rsp_taken) begin
         seen.port_value = rsp_bus.port_value;
         seen.autofiring = rsp_bus.autofiring;
         if (port_forecast.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual port_value %h autofiring %b",
                     $time, seen.port_value, seen.autofiring);
            error_count++;
         end else begin
            want = port_forecast.pop_front();
            if (seen.port_value !== want.port_value) begin
               $display("%0t: port_value mismatch, expected %h, actual %h",
                        $time, want.port_value, seen.port_value);
               error_count++;
            end
            if (seen.autofiring !== want.autofiring) begin
               $display("%0t: autofiring mismatch, expected %b, actual %b",
                        $time, want.autofiring, seen.autofiring);
               error_count++;
            end
         end
      end
   end

   initial begin : watchdog
      @(negedge clock);
      while (idle_cycles < IdleLimit) @(negedge clock);
      $display("[joystick_port_with_autofire_core] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus

   task automatic queue_action(input logic [ReqTypeWidth-1:0] kind,
                               input logic [FrameWidth-1:0] frame);
      stick_action_type a;
      a.kind  = kind;
      a.frame = frame;
      action_backlog.push_back(a);
   endtask

   task automatic write_csr(input logic [CsrIndexWidth-1:0] index,
                            input logic [CsrDataWidth-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      case (index)
         CSR_AUTOFIRE_ENABLE: cfg.autofire_enable = value[0];
         CSR_BURST_MODE:      cfg.burst_mode      = value[0];
         CSR_BURST_BULLETS:   cfg.burst_bullets   = value;
         CSR_AUTOFIRE_DELAY:  cfg.autofire_delay  = value;
         default: ;
      endcase
   endtask

   // one-bit registers get junk in the upper bits to exercise the masking
   task automatic apply_settings(input logic enable, input logic burst,
                                 input logic [CountWidth-1:0] bullets,
                                 input logic [CountWidth-1:0] gap);
      write_csr(CSR_AUTOFIRE_ENABLE, {7'($urandom), enable});
      write_csr(CSR_BURST_MODE, {7'($urandom), burst});
      write_csr(CSR_BURST_BULLETS, bullets);
      write_csr(CSR_AUTOFIRE_DELAY, gap);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle();
      while (action_backlog.size() != 0 || req_bus.valid || port_forecast.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   function automatic logic [CountWidth-1:0] pick_count();
      int roll;
      roll = $urandom_range(19);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return CountWidth'($urandom_range(1, 6));
   endfunction

   // mostly consecutive frame ticks so runs actually play out, with fire
   // presses at the current frame and some out-of-order ticks as noise
   task automatic queue_random_play(input int count, input logic [FrameWidth-1:0] start);
      logic [FrameWidth-1:0] now;
      int roll;
      int k;
      now = start;
      for (k = 0; k < count; k++) begin
         roll = $urandom_range(99);
         if (roll < 55) begin
            queue_action(REQ_FRAME_TICK, now);
            now = now + 1'b1;
         end else if (roll < 65) begin
            queue_action(REQ_PRESS_FIRE, now);
         end else if (roll < 69) begin
            queue_action(REQ_RELEASE_FIRE, $urandom);
         end else if (roll < 92) begin
            queue_action(ReqTypeWidth'($urandom_range(REQ_UP, REQ_RELEASE_XY)), $urandom);
         end else if (roll < 95) begin
            queue_action(ReqTypeWidth'($urandom_range(REQ_UNUSED_LOW, REQ_UNUSED_HIGH)),
                         $urandom);
         end else if (roll < 98) begin
            queue_action(REQ_FRAME_TICK, $urandom);
         end else begin
            now = now + FrameWidth'($urandom_range(1, 300));
            queue_action(REQ_FRAME_TICK, now);
         end
      end
   endtask

   initial begin : run_test
      int p;
      logic [FrameWidth-1:0] start;
      csr_write_enable     = 1'b0;
      csr_index            = CSR_AUTOFIRE_ENABLE;
      csr_write_data       = '0;
      reset                = 1'b1;
      cfg.autofire_enable  = 1'b0;
      cfg.burst_mode       = 1'b0;
      cfg.burst_bullets    = BURST_BULLETS_RESET;
      cfg.autofire_delay   = AUTOFIRE_DELAY_RESET;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 12;
      recv_idle_pct = 59;

      // plain joystick under reset settings
      queue_action(REQ_UP, $urandom);
      queue_action(REQ_DOWN, $urandom);
      queue_action(REQ_LEFT, $urandom);
      queue_action(REQ_RIGHT, $urandom);
      queue_action(REQ_RELEASE_X, $urandom);
      queue_action(REQ_RELEASE_Y, $urandom);
      queue_action(REQ_LEFT, $urandom);
      queue_action(REQ_UP, $urandom);
      queue_action(REQ_RELEASE_XY, $urandom);
      queue_action(REQ_PRESS_FIRE, $urandom);
      queue_action(REQ_RELEASE_FIRE, $urandom);
      queue_action(REQ_UNUSED_LOW, $urandom);
      queue_action(REQ_UNUSED_HIGH, $urandom);
      queue_action(REQ_FRAME_TICK, '1);
      queue_action(REQ_FRAME_TICK, '0);
      settle();

      // one-shot burst from cleared frames: spurious press at frame 0
      apply_settings(1'b1, 1'b1, 8'd1, 8'd1);
      queue_action(REQ_PRESS_FIRE, '0);
      queue_action(REQ_FRAME_TICK, '0);
      queue_action(REQ_FRAME_TICK, 32'd1);
      queue_action(REQ_RELEASE_FIRE, $urandom);
      settle();

      // continuous run whose release frame wraps, ended by a second press
      apply_settings(1'b1, 1'b0, 8'd0, 8'd255);
      queue_action(REQ_PRESS_FIRE, 32'hFFFF_FFF0);
      queue_action(REQ_FRAME_TICK, 32'h0000_00EF);
      queue_action(REQ_PRESS_FIRE, $urandom);
      settle();

      // empty magazine: start leaves the button held with no run
      apply_settings(1'b1, 1'b1, 8'd0, 8'd0);
      queue_action(REQ_PRESS_FIRE, 32'd7);
      queue_action(REQ_FRAME_TICK, 32'd7);
      queue_action(REQ_PRESS_FIRE, 32'd9);
      settle();

      for (p = 0; p < RandomPhases; p++) begin
         case (p)
            0:       apply_settings(1'b1, 1'b1, 8'd1, 8'd1);
            1:       apply_settings(1'b1, 1'b0, 8'd255, 8'd255);
            2:       apply_settings(1'b1, 1'b1, 8'd255, 8'd1);
            3:       apply_settings(1'b0, 1'($urandom), pick_count(), pick_count());
            4:       apply_settings(1'b1, 1'b1, 8'd0, 8'd0);
            default: apply_settings($urandom_range(4) != 0, 1'($urandom),
                                    pick_count(), pick_count());
         endcase
         if (p == RandomPhases / 3) begin
            send_idle_pct = 59;
            recv_idle_pct = 12;
         end
         if (p == 2 * RandomPhases / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            hold_off_request = 1'b1;
         end
         case (p % 3)
            0:       start = '0;
            1:       start = 32'hFFFF_FFFF - FrameWidth'($urandom_range(0, 40));
            default: start = $urandom;
         endcase
         queue_random_play(PhaseItems, start);
         settle();
      end

      if (port_forecast.size() != 0) begin
         $display("%0t: %0d transactions expected, actual none",
                  $time, port_forecast.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("[joystick_port_with_autofire_core] OK");
      end else begin
         $display("[joystick_port_with_autofire_core] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
